/* rtl/mbet_pkg.sv */
// Shared types, constants and helpers for the escape-time pixel engine.
// No dependencies; imported by every module of the block.
package mbet_pkg;

   localparam int unsigned Z_BITS      = 32;
   localparam int unsigned CNT_BITS    = 16;
   localparam int unsigned GREY_BITS   = 8;
   localparam int unsigned STEP_BITS   = 31;
   localparam int unsigned WIDE_BITS   = 66;
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned QUEUE_DEPTH = 2;

   // floor(n / 10) == (n * 52429) >> 19 for every 16-bit n
   localparam logic [CNT_BITS-1:0] DIV10_MULT  = 16'd52429;
   localparam int unsigned         DIV10_SHIFT = 19;

   localparam logic [CNT_BITS-1:0]  LIMIT_RESET  = 16'd1000;
   localparam logic [STEP_BITS-1:0] STEP_RESET   = 31'd1533916;
   localparam logic [Z_BITS-1:0]    ORIGIN_RESET = 32'hE000_0000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ITER_LIMIT  = 3'd0,
      CSR_STEP_REAL   = 3'd1,
      CSR_STEP_IMAG   = 3'd2,
      CSR_ORIGIN_REAL = 3'd3,
      CSR_ORIGIN_IMAG = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]  iteration_limit;
      logic [STEP_BITS-1:0] step_real;
      logic [STEP_BITS-1:0] step_imag;
      logic [Z_BITS-1:0]    origin_real;
      logic [Z_BITS-1:0]    origin_imag;
   } csr_type;

   // Clamp a wide signed value into the signed 32-bit range.
   function automatic logic signed [Z_BITS-1:0] sat_z(input logic signed [WIDE_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] max_v;
      logic signed [WIDE_BITS-1:0] min_v;
      max_v = WIDE_BITS'(signed'(33'sh0_7FFF_FFFF));
      min_v = WIDE_BITS'(signed'(33'sh1_8000_0000));
      if (v > max_v) begin
         sat_z = 32'sh7FFF_FFFF;
      end else if (v < min_v) begin
         sat_z = 32'sh8000_0000;
      end else begin
         sat_z = v[Z_BITS-1:0];
      end
   endfunction

endpackage

/* rtl/mandelbrot_escape_time_pixel.sv */
// Top level of the escape-time pixel engine: configuration registers and
// the front end, queue and iteration engine. Depends on mbet_pkg.
//
// Usage:
//   req_*  : one pixel per transfer, req_tdata = {row, col} (col in the low bits).
//   rsp_*  : one result per pixel, in order: col, row, escape count, grey level.
//   csr_*  : register writes, csr_index selects the register, always ready.
//            Write only while the engine is idle.
// Dataflow:
//   The front end maps a pixel to c with a registered multiply, then a
//   combinational offset and clamp, and pushes it into a two-entry queue. The
//   iteration engine pops a point, then runs each iteration as state ST_MUL,
//   for the three 32x32 products, then ST_EVAL, for the escape test and z
//   update. It takes a new point only when idle, once the result of the last
//   point is loaded into its output register.
// Reset (synchronous, active high) empties all stages and loads the register
// defaults: limit 1000, steps 1533916, origins -2.0 in Q4.28.
// A stalled rsp_tready holds the result; the engine waits on its last test
// and the front end keeps filling the queue until it is full.
module mandelbrot_escape_time_pixel
   import mbet_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12,
   parameter int unsigned FRAC_BITS  = 28
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel input
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [col, row] from bit 0 up, zero padded to whole bytes
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   // result output
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [out_col, out_row, escape_count, grey_level] from bit 0 up, zero padded
   output logic [((2*COORD_BITS+31)/8)*8-1:0]    rsp_tdata,
   // register writes
   input  logic                                  csr_tvalid,
   output logic                                  csr_tready,
   input  logic [CSR_IDX_BITS-1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0]              csr_wdata
);

   localparam int unsigned PT_BITS = 2*COORD_BITS + 2*Z_BITS;

   csr_type              csr_ff;
   logic                 fe_valid;
   logic                 fe_ready;
   logic [PT_BITS-1:0]   fe_data;
   logic                 be_valid;
   logic                 be_ready;
   logic [PT_BITS-1:0]   be_data;

   assign csr_tready = 1'b1;

   // Register file: writes to unused indexes drop silently.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.iteration_limit <= LIMIT_RESET;
         csr_ff.step_real       <= STEP_RESET;
         csr_ff.step_imag       <= STEP_RESET;
         csr_ff.origin_real     <= ORIGIN_RESET;
         csr_ff.origin_imag     <= ORIGIN_RESET;
      end else if (csr_tvalid && csr_tready) begin
         case (csr_index)
            CSR_ITER_LIMIT:  csr_ff.iteration_limit <= csr_wdata[CNT_BITS-1:0];
            CSR_STEP_REAL:   csr_ff.step_real       <= csr_wdata[STEP_BITS-1:0];
            CSR_STEP_IMAG:   csr_ff.step_imag       <= csr_wdata[STEP_BITS-1:0];
            CSR_ORIGIN_REAL: csr_ff.origin_real     <= csr_wdata[Z_BITS-1:0];
            CSR_ORIGIN_IMAG: csr_ff.origin_imag     <= csr_wdata[Z_BITS-1:0];
            default:         csr_ff                 <= csr_ff;
         endcase
      end
   end

   // Map pixels to points.
   mbet_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .pix_valid (req_tvalid),
      .pix_ready (req_tready),
      .pix_col   (req_tdata[COORD_BITS-1:0]),
      .pix_row   (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .pt_valid  (fe_valid),
      .pt_ready  (fe_ready),
      .pt_data   (fe_data)
   );

   // Decouple mapping from iteration.
   mbet_queue #(
      .WIDTH (PT_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   (fe_data),
      .out_valid (be_valid),
      .out_ready (be_ready),
      .out_data  (be_data)
   );

   // Iterate and hold the result.
   mbet_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .iteration_limit (csr_ff.iteration_limit),
      .pt_valid        (be_valid),
      .pt_ready        (be_ready),
      .pt_data         (be_data),
      .res_valid       (rsp_tvalid),
      .res_ready       (rsp_tready),
      .res_data        (rsp_tdata)
   );

endmodule

/* rtl/mbet_queue.sv */
// Two-entry FIFO between the point mapper and the iteration engine.
// Depends on mbet_pkg for the depth.
module mbet_queue
   import mbet_pkg::*;
#(
   parameter int unsigned WIDTH = 88
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W    = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* rtl/mbet_front.sv */
// Front end: accepts pixels and maps them to the complex point c.
// Depends on mbet_pkg (csr_type, sat_z); feeds mbet_queue.
module mbet_front
   import mbet_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  csr_type                            csr,
   input  logic                               pix_valid,
   output logic                               pix_ready,
   input  logic [COORD_BITS-1:0]              pix_col,
   input  logic [COORD_BITS-1:0]              pix_row,
   output logic                               pt_valid,
   input  logic                               pt_ready,
   // {row, col, c_imag, c_real} from the top bit down
   output logic [2*COORD_BITS+2*Z_BITS-1:0]   pt_data
);

   localparam int unsigned PROD_BITS = COORD_BITS + STEP_BITS;

   logic                         s1_valid_ff;
   logic [COORD_BITS-1:0]        col_ff;
   logic [COORD_BITS-1:0]        row_ff;
   logic [PROD_BITS-1:0]         prod_r_ff;
   logic [PROD_BITS-1:0]         prod_i_ff;
   logic signed [WIDE_BITS-1:0]  sum_r;
   logic signed [WIDE_BITS-1:0]  sum_i;
   logic signed [Z_BITS-1:0]     c_real;
   logic signed [Z_BITS-1:0]     c_imag;
   logic                         take;

   assign pix_ready = !s1_valid_ff || pt_ready;
   assign take      = pix_valid && pix_ready;

   // Offset by the origin, then clamp.
   assign sum_r = $signed({{(WIDE_BITS-Z_BITS){csr.origin_real[Z_BITS-1]}}, csr.origin_real})
                + $signed({{(WIDE_BITS-PROD_BITS){1'b0}}, prod_r_ff});
   assign sum_i = $signed({{(WIDE_BITS-Z_BITS){csr.origin_imag[Z_BITS-1]}}, csr.origin_imag})
                + $signed({{(WIDE_BITS-PROD_BITS){1'b0}}, prod_i_ff});
   assign c_real = sat_z(sum_r);
   assign c_imag = sat_z(sum_i);

   assign pt_valid = s1_valid_ff;
   assign pt_data  = {row_ff, col_ff, c_imag, c_real};

   always_ff @(posedge clock) begin
      if (take) begin
         col_ff    <= pix_col;
         row_ff    <= pix_row;
         prod_r_ff <= PROD_BITS'(pix_col) * PROD_BITS'(csr.step_real);
         prod_i_ff <= PROD_BITS'(pix_row) * PROD_BITS'(csr.step_imag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (pt_ready) begin
         s1_valid_ff <= 1'b0;
      end
   end

endmodule

/* rtl/mbet_back.sv */
// Back end: iterates z = z*z + c for one point at a time and holds the result.
// Depends on mbet_pkg (sat_z, constants); takes points from mbet_queue.
module mbet_back
   import mbet_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12,
   parameter int unsigned FRAC_BITS  = 28
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [CNT_BITS-1:0]                     iteration_limit,
   input  logic                                    pt_valid,
   output logic                                    pt_ready,
   input  logic [2*COORD_BITS+2*Z_BITS-1:0]        pt_data,
   output logic                                    res_valid,
   input  logic                                    res_ready,
   output logic [((2*COORD_BITS+31)/8)*8-1:0]      res_data
);

   localparam int unsigned RES_BITS = ((2*COORD_BITS + 31) / 8) * 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL
   } state_type;

   state_type                   state_ff;
   logic signed [Z_BITS-1:0]    cr_ff;
   logic signed [Z_BITS-1:0]    ci_ff;
   logic [COORD_BITS-1:0]       col_ff;
   logic [COORD_BITS-1:0]       row_ff;
   logic signed [Z_BITS-1:0]    x_ff;
   logic signed [Z_BITS-1:0]    y_ff;
   logic [CNT_BITS-1:0]         n_ff;
   logic signed [63:0]          xx_prod_ff;
   logic signed [63:0]          yy_prod_ff;
   logic signed [63:0]          xy_prod_ff;
   logic                        res_valid_ff;
   logic [RES_BITS-1:0]         res_data_ff;

   logic [WIDE_BITS-1:0]        xx_w;
   logic [WIDE_BITS-1:0]        yy_w;
   logic [WIDE_BITS-1:0]        four_w;
   logic                        escaped;
   logic                        finished;
   logic signed [WIDE_BITS-1:0] xy2_w;
   logic signed [WIDE_BITS-1:0] nx_w;
   logic signed [WIDE_BITS-1:0] ny_w;
   logic [2*CNT_BITS-1:0]       tenth_prod;
   logic [GREY_BITS-1:0]        grey;
   logic                        res_free;
   logic                        load_res;

   assign pt_ready  = (state_ff == ST_IDLE);
   assign res_valid = res_valid_ff;
   assign res_data  = res_data_ff;
   assign res_free  = !res_valid_ff || res_ready;
   assign load_res  = (state_ff == ST_EVAL) && finished && res_free;

   // Truncated squares (products are never negative), escape test on their sum.
   assign xx_w     = {2'b00, xx_prod_ff} >> FRAC_BITS;
   assign yy_w     = {2'b00, yy_prod_ff} >> FRAC_BITS;
   assign four_w   = WIDE_BITS'(4) << FRAC_BITS;
   assign escaped  = (xx_w + yy_w) > four_w;
   assign finished = escaped || (n_ff >= iteration_limit);

   // Cross term 2xy: arithmetic shift floors toward minus infinity.
   assign xy2_w = $signed({{2{xy_prod_ff[63]}}, xy_prod_ff}) >>> (FRAC_BITS - 1);
   assign nx_w  = $signed(xx_w) - $signed(yy_w)
                + $signed({{(WIDE_BITS-Z_BITS){cr_ff[Z_BITS-1]}}, cr_ff});
   assign ny_w  = xy2_w + $signed({{(WIDE_BITS-Z_BITS){ci_ff[Z_BITS-1]}}, ci_ff});

   // grey = floor(51 n / 10) mod 256 = (5n + floor(n / 10)) mod 256
   assign tenth_prod = (2*CNT_BITS)'(n_ff) * (2*CNT_BITS)'(DIV10_MULT);
   assign grey = GREY_BITS'({n_ff, 2'b00}) + GREY_BITS'(n_ff)
               + GREY_BITS'(tenth_prod >> DIV10_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         if (res_valid_ff && res_ready && !load_res) begin
            res_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pt_valid) begin
                  cr_ff    <= pt_data[Z_BITS-1:0];
                  ci_ff    <= pt_data[2*Z_BITS-1:Z_BITS];
                  col_ff   <= pt_data[2*Z_BITS+COORD_BITS-1:2*Z_BITS];
                  row_ff   <= pt_data[2*Z_BITS+2*COORD_BITS-1:2*Z_BITS+COORD_BITS];
                  x_ff     <= '0;
                  y_ff     <= '0;
                  n_ff     <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               xx_prod_ff <= x_ff * x_ff;
               yy_prod_ff <= y_ff * y_ff;
               xy_prod_ff <= x_ff * y_ff;
               state_ff   <= ST_EVAL;
            end
            ST_EVAL: begin
               if (finished) begin
                  // Hold here until the result register frees up.
                  if (res_free) begin
                     res_valid_ff <= 1'b1;
                     res_data_ff  <= RES_BITS'({grey, n_ff, row_ff, col_ff});
                     state_ff     <= ST_IDLE;
                  end
               end else begin
                  x_ff     <= sat_z(nx_w);
                  y_ff     <= sat_z(ny_w);
                  n_ff     <= n_ff + 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
